>>> hw/rtl/spmq_pkg.sv
// Package for the sorted priority message queue.
// Holds the default sizes, the word codes, the FSM states and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spmq_pkg;

  localparam int DefQueueDepth  = 16;
  localparam int DefPayloadMax  = 32;
  localparam int DefHeaderWidth = 32;

  typedef enum logic [1:0] {
    MODE_ENQ_HDR = 2'd0,
    MODE_BYTE    = 2'd1,
    MODE_DEQ     = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_BYTE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_e;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_SEND = 1'b1
  } ctl_state_e;

  // Per-cell control: what to do this cycle and where the cell sits.
  typedef struct packed {
    cell_op_e op;
    logic     is_valid;   // slot holds a message
    logic     is_held;    // slot is the first free one
    logic     below_top;  // slot takes its right neighbor on dequeue
    logic     at_top;     // slot receives the freed row pointer on dequeue
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/spmq_payload_ram.sv
// Payload byte memory, one row per row pointer.
// Depends on nothing; one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module spmq_payload_ram #(
  parameter int AddrWidth = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [7:0]           wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [7:0]           rdata_o
);

  logic [7:0] mem [2**AddrWidth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/spmq_cell.sv
// One slot of the sorted chain: priority, header, length and payload row pointer.
// Depends on spmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spmq_cell
  import spmq_pkg::*;
#(
  parameter int HeaderWidth = DefHeaderWidth,
  parameter int LenWidth    = 6,
  parameter int PtrWidth    = 4,
  parameter int ResetPtr    = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [7:0]             new_prio_i,
  input  wire logic [HeaderWidth-1:0] new_hdr_i,
  input  wire logic [LenWidth-1:0]    new_len_i,
  input  wire logic [PtrWidth-1:0]    stage_ptr_i,
  input  wire logic [PtrWidth-1:0]    head_ptr_i,
  input  wire logic                   g_left_i,
  input  wire logic [7:0]             left_prio_i,
  input  wire logic [HeaderWidth-1:0] left_hdr_i,
  input  wire logic [LenWidth-1:0]    left_len_i,
  input  wire logic [PtrWidth-1:0]    left_ptr_i,
  input  wire logic [7:0]             right_prio_i,
  input  wire logic [HeaderWidth-1:0] right_hdr_i,
  input  wire logic [LenWidth-1:0]    right_len_i,
  input  wire logic [PtrWidth-1:0]    right_ptr_i,
  output logic                        g_o,
  output logic      [7:0]             prio_o,
  output logic      [HeaderWidth-1:0] hdr_o,
  output logic      [LenWidth-1:0]    len_o,
  output logic      [PtrWidth-1:0]    ptr_o
);

  logic [7:0]             prio_q, prio_d;
  logic [HeaderWidth-1:0] hdr_q, hdr_d;
  logic [LenWidth-1:0]    len_q, len_d;
  logic [PtrWidth-1:0]    ptr_q, ptr_d;

  // New message goes in front of the first entry with a strictly larger priority.
  assign g_o = ctrl_i.is_valid && (new_prio_i < prio_q);

  always_comb begin
    prio_d = prio_q;
    hdr_d  = hdr_q;
    len_d  = len_q;
    ptr_d  = ptr_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (g_left_i) begin
          prio_d = left_prio_i;
          hdr_d  = left_hdr_i;
          len_d  = left_len_i;
          ptr_d  = left_ptr_i;
        end else if (g_o || ctrl_i.is_held) begin
          prio_d = new_prio_i;
          hdr_d  = new_hdr_i;
          len_d  = new_len_i;
          ptr_d  = stage_ptr_i;
        end
      end
      OP_SHIFT: begin
        if (ctrl_i.at_top) begin
          ptr_d = head_ptr_i;
        end else if (ctrl_i.below_top) begin
          prio_d = right_prio_i;
          hdr_d  = right_hdr_i;
          len_d  = right_len_i;
          ptr_d  = right_ptr_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= PtrWidth'(ResetPtr);
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    hdr_q  <= hdr_d;
    len_q  <= len_d;
  end

  assign prio_o = prio_q;
  assign hdr_o  = hdr_q;
  assign len_o  = len_q;
  assign ptr_o  = ptr_q;

endmodule
`default_nettype wire

>>> hw/rtl/sorted_priority_message_queue_top.sv
// Top level of the sorted priority message queue: control, cell chain, payload memory.
// Depends on spmq_pkg, spmq_cell, spmq_payload_ram.
//
//   channel | handshake          | words
//   --------+--------------------+------------------------------------------------
//   in      | start / busy       | mode, priority_req, header_word, message_length,
//           |                    | data_byte, max_copy
//   out     | done_o (strobe)    | status, out_priority, out_header, full_length,
//           |                    | out_byte, last, count, is_empty
//
// Enqueue header, payload byte and clear: the result shows in the cycle after the
// accept. Dequeue gives its header result the cycle after the accept, then one byte
// per cycle from the payload memory read port, busy held high until the last byte
// is out.
// Insert and dequeue move the whole cell chain in one step; payload bytes never
// move, each cell carries a pointer to its row.
// Reset: held count and pending message clear; cell i's row pointer returns to row i.
// The receiver cannot stall: each result is on the ports for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_message_queue_top
  import spmq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DefQueueDepth,
  parameter int PAYLOAD_MAX  = DefPayloadMax,
  parameter int HEADER_WIDTH = DefHeaderWidth,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int LW = $clog2(PAYLOAD_MAX + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              mode_i,
  input  wire logic [7:0]              priority_req_i,
  input  wire logic [HEADER_WIDTH-1:0] header_word_i,
  input  wire logic [7:0]              message_length_i,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic [7:0]              max_copy_i,
  output logic                         done_o,
  output logic      [2:0]              status_o,
  output logic      [7:0]              out_priority_o,
  output logic      [HEADER_WIDTH-1:0] out_header_o,
  output logic      [LW-1:0]           full_length_o,
  output logic      [7:0]              out_byte_o,
  output logic                         last_o,
  output logic      [CW-1:0]           count_o,
  output logic                         is_empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int IW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  // ---------------- control registers ----------------
  ctl_state_e              state_q, state_d;
  logic [CW-1:0]           held_q, held_d;
  logic                    pend_q, pend_d;
  logic [7:0]              pprio_q, pprio_d;
  logic [HEADER_WIDTH-1:0] phdr_q, phdr_d;
  logic [LW-1:0]           plen_q, plen_d;
  logic [LW-1:0]           seen_q, seen_d;
  logic [PW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]           idx_q, idx_d, ncopy_q, ncopy_d;

  // result registers
  logic                    done_q, done_d;
  status_e                 status_q, status_d;
  logic [7:0]              oprio_q, oprio_d;
  logic [HEADER_WIDTH-1:0] ohdr_q, ohdr_d;
  logic [LW-1:0]           olen_q, olen_d;
  logic                    last_q, last_d;
  logic                    bsel_q, bsel_d;

  // ---------------- cell chain wiring ----------------
  cell_op_e                op;
  logic [7:0]              new_prio;
  logic [HEADER_WIDTH-1:0] new_hdr;
  logic [LW-1:0]           new_len;
  logic [PW-1:0]           stage_ptr;
  logic [CW-1:0]           top_idx;

  logic [7:0]              c_prio [QUEUE_DEPTH];
  logic [HEADER_WIDTH-1:0] c_hdr  [QUEUE_DEPTH];
  logic [LW-1:0]           c_len  [QUEUE_DEPTH];
  logic [PW-1:0]           c_ptr  [QUEUE_DEPTH];
  logic                    c_g    [QUEUE_DEPTH];

  // payload memory
  logic                    mem_we;
  logic [PW+IW-1:0]        mem_waddr, mem_raddr;
  logic [7:0]              mem_rdata;

  logic                    accept;
  logic [LW-1:0]           ncopy;
  logic [LW-1:0]           seen_inc;

  assign accept   = start && !busy;
  assign busy     = (state_q == CTL_SEND);
  assign seen_inc = seen_q + LW'(1);

  // Row where a pending message's bytes are staged: the first free slot's row.
  assign stage_ptr = (held_q < CW'(QUEUE_DEPTH)) ? c_ptr[held_q[PW-1:0]] : c_ptr[0];
  assign top_idx   = (held_q < CW'(QUEUE_DEPTH)) ? held_q : CW'(QUEUE_DEPTH - 1);

  assign ncopy = (max_copy_i < 8'(c_len[0])) ? LW'(max_copy_i) : c_len[0];

  assign mem_waddr = {stage_ptr, seen_q[IW-1:0]};
  assign mem_raddr = {rd_ptr_q, idx_q[IW-1:0]};

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    pend_d   = pend_q;
    pprio_d  = pprio_q;
    phdr_d   = phdr_q;
    plen_d   = plen_q;
    seen_d   = seen_q;
    rd_ptr_d = rd_ptr_q;
    idx_d    = idx_q;
    ncopy_d  = ncopy_q;
    done_d   = 1'b0;
    status_d = ST_OK;
    oprio_d  = '0;
    ohdr_d   = '0;
    olen_d   = '0;
    last_d   = 1'b1;
    bsel_d   = 1'b0;
    op       = OP_HOLD;
    new_prio = pprio_q;
    new_hdr  = phdr_q;
    new_len  = plen_q;
    mem_we   = 1'b0;

    case (state_q)
      CTL_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (mode_e'(mode_i))
            MODE_ENQ_HDR: begin
              pend_d = 1'b0;
              seen_d = '0;
              if (message_length_i > 8'(PAYLOAD_MAX)) begin
                status_d = ST_TOO_LONG;
              end else if (held_q == CW'(QUEUE_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                pprio_d = priority_req_i;
                phdr_d  = header_word_i;
                plen_d  = LW'(message_length_i);
                if (message_length_i == 8'd0) begin
                  // empty payload joins the queue at once
                  op       = OP_INSERT;
                  new_prio = priority_req_i;
                  new_hdr  = header_word_i;
                  new_len  = '0;
                  held_d   = held_q + CW'(1);
                end else begin
                  pend_d = 1'b1;
                end
              end
            end
            MODE_BYTE: begin
              if (pend_q && (held_q < CW'(QUEUE_DEPTH)) && (seen_q < plen_q)) begin
                mem_we = 1'b1;
                seen_d = seen_inc;
                if (seen_inc >= plen_q) begin
                  op     = OP_INSERT;
                  held_d = held_q + CW'(1);
                  pend_d = 1'b0;
                  seen_d = '0;
                end
              end
            end
            MODE_DEQ: begin
              if (held_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                op       = OP_SHIFT;
                held_d   = held_q - CW'(1);
                oprio_d  = c_prio[0];
                ohdr_d   = c_hdr[0];
                olen_d   = c_len[0];
                last_d   = (ncopy == '0);
                rd_ptr_d = c_ptr[0];
                idx_d    = '0;
                ncopy_d  = ncopy;
                if (ncopy != '0) begin
                  state_d = CTL_SEND;
                end
              end
            end
            MODE_CLEAR: begin
              held_d = '0;
              pend_d = 1'b0;
              seen_d = '0;
            end
            default: ;
          endcase
        end
      end
      CTL_SEND: begin
        // memory read of byte idx lands with this result
        done_d   = 1'b1;
        status_d = ST_BYTE;
        bsel_d   = 1'b1;
        last_d   = (LW'(idx_q + LW'(1)) == ncopy_q);
        idx_d    = idx_q + LW'(1);
        if (last_d) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      held_q  <= '0;
      pend_q  <= 1'b0;
      seen_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      seen_q  <= seen_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pprio_q  <= pprio_d;
    phdr_q   <= phdr_d;
    plen_q   <= plen_d;
    rd_ptr_q <= rd_ptr_d;
    idx_q    <= idx_d;
    ncopy_q  <= ncopy_d;
    status_q <= status_d;
    oprio_q  <= oprio_d;
    ohdr_q   <= ohdr_d;
    olen_q   <= olen_d;
    last_q   <= last_d;
    bsel_q   <= bsel_d;
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t              ctrl;
    logic                    g_left;
    logic [7:0]              l_prio, r_prio;
    logic [HEADER_WIDTH-1:0] l_hdr, r_hdr;
    logic [LW-1:0]           l_len, r_len;
    logic [PW-1:0]           l_ptr, r_ptr;

    assign ctrl.op        = op;
    assign ctrl.is_valid  = (CW'(i) < held_q);
    assign ctrl.is_held   = (CW'(i) == held_q);
    assign ctrl.below_top = (CW'(i) < top_idx);
    assign ctrl.at_top    = (CW'(i) == top_idx);

    if (i == 0) begin : g_first
      assign g_left = 1'b0;
      assign l_prio = '0;
      assign l_hdr  = '0;
      assign l_len  = '0;
      assign l_ptr  = '0;
    end else begin : g_mid
      assign g_left = c_g[i-1];
      assign l_prio = c_prio[i-1];
      assign l_hdr  = c_hdr[i-1];
      assign l_len  = c_len[i-1];
      assign l_ptr  = c_ptr[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_prio = c_prio[i];
      assign r_hdr  = c_hdr[i];
      assign r_len  = c_len[i];
      assign r_ptr  = c_ptr[i];
    end else begin : g_inner
      assign r_prio = c_prio[i+1];
      assign r_hdr  = c_hdr[i+1];
      assign r_len  = c_len[i+1];
      assign r_ptr  = c_ptr[i+1];
    end

    spmq_cell #(
      .HeaderWidth (HEADER_WIDTH),
      .LenWidth    (LW),
      .PtrWidth    (PW),
      .ResetPtr    (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_prio_i   (new_prio),
      .new_hdr_i    (new_hdr),
      .new_len_i    (new_len),
      .stage_ptr_i  (stage_ptr),
      .head_ptr_i   (c_ptr[0]),
      .g_left_i     (g_left),
      .left_prio_i  (l_prio),
      .left_hdr_i   (l_hdr),
      .left_len_i   (l_len),
      .left_ptr_i   (l_ptr),
      .right_prio_i (r_prio),
      .right_hdr_i  (r_hdr),
      .right_len_i  (r_len),
      .right_ptr_i  (r_ptr),
      .g_o          (c_g[i]),
      .prio_o       (c_prio[i]),
      .hdr_o        (c_hdr[i]),
      .len_o        (c_len[i]),
      .ptr_o        (c_ptr[i])
    );
  end

  // ---------------- payload memory ----------------
  spmq_payload_ram #(
    .AddrWidth (PW + IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_byte_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------- result ports ----------------
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = oprio_q;
  assign out_header_o   = ohdr_q;
  assign full_length_o  = olen_q;
  assign out_byte_o     = bsel_q ? mem_rdata : 8'd0;
  assign last_o         = last_q;
  assign count_o        = held_q;
  assign is_empty_o     = (held_q == '0);

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for sorted_priority_message_queue_top: directed words, then random traffic.
// Depends on spmq_pkg and the queue RTL; predictions come from a scoreboard class in this file.
`timescale 1ns / 1ps
module tb_top;
  import spmq_pkg::*;

  localparam int Depth  = DefQueueDepth;
  localparam int PayMax = DefPayloadMax;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pri;
    logic [31:0] hdr;
    logic [5:0]  flen;
    logic [7:0]  byte_v;
    logic        last;
    logic [4:0]  count;
    logic        empty;
  } qresult_t;

  // Tracks queue contents and the results each accepted word should produce.
  class queue_scoreboard;
    logic [7:0]  slot_pri [Depth];
    logic [31:0] slot_hdr [Depth];
    logic [5:0]  slot_len [Depth];
    logic [7:0]  slot_row [Depth][PayMax];
    int          held;
    bit          pend_v;
    logic [7:0]  pend_pri;
    logic [31:0] pend_hdr;
    int          pend_len;
    int          seen;
    qresult_t    due_q[$];
    int          errors;

    function new();
      held = 0; pend_v = 0; seen = 0; errors = 0;
    endfunction

    function void push(status_e st, logic [7:0] p, logic [31:0] h, logic [5:0] l,
                       logic [7:0] b, logic lst);
      qresult_t r;
      r.status = st; r.pri = p; r.hdr = h; r.flen = l; r.byte_v = b; r.last = lst;
      r.count = held[4:0]; r.empty = (held == 0);
      due_q.push_back(r);
    endfunction

    // Pending message goes ahead of the first entry with a strictly larger priority.
    function void insert_pending();
      logic [7:0] staged [PayMax];
      int pos;
      pos = held;
      if (held >= Depth) begin
        pend_v = 0;
        return;
      end
      for (int i = 0; i < held; i++)
        if (pend_pri < slot_pri[i]) begin
          pos = i;
          break;
        end
      staged = slot_row[held];
      for (int i = held; i > pos; i--) begin
        slot_pri[i] = slot_pri[i-1];
        slot_hdr[i] = slot_hdr[i-1];
        slot_len[i] = slot_len[i-1];
        slot_row[i] = slot_row[i-1];
      end
      slot_pri[pos] = pend_pri;
      slot_hdr[pos] = pend_hdr;
      slot_len[pos] = pend_len[5:0];
      slot_row[pos] = staged;
      held++;
      pend_v = 0;
      seen = 0;
    endfunction

    function void note_word(mode_e m, logic [7:0] p, logic [31:0] h, logic [7:0] len,
                            logic [7:0] db, logic [7:0] mc);
      logic [7:0]  hp;
      logic [31:0] hh;
      logic [5:0]  hl;
      logic [7:0]  row [PayMax];
      int          top;
      int          ncopy;
      case (m)
        MODE_ENQ_HDR: begin
          pend_v = 0;
          seen = 0;
          if (len > PayMax) push(ST_TOO_LONG, 0, 0, 0, 0, 1);
          else if (held >= Depth) push(ST_FULL, 0, 0, 0, 0, 1);
          else begin
            pend_v = 1; pend_pri = p; pend_hdr = h; pend_len = len;
            if (len == 0) insert_pending();
            push(ST_OK, 0, 0, 0, 0, 1);
          end
        end
        MODE_BYTE: begin
          if (pend_v && held < Depth && seen < pend_len && seen < PayMax) begin
            slot_row[held][seen] = db;
            seen++;
            if (seen >= pend_len) insert_pending();
          end
          push(ST_OK, 0, 0, 0, 0, 1);
        end
        MODE_DEQ: begin
          if (held == 0) push(ST_EMPTY, 0, 0, 0, 0, 1);
          else begin
            hp = slot_pri[0]; hh = slot_hdr[0]; hl = slot_len[0]; row = slot_row[0];
            // staged bytes of a pending message slide down with the held rows
            top = (!pend_v || held >= Depth) ? held - 1 : held;
            for (int i = 1; i <= top && i < Depth; i++) begin
              slot_pri[i-1] = slot_pri[i];
              slot_hdr[i-1] = slot_hdr[i];
              slot_len[i-1] = slot_len[i];
              slot_row[i-1] = slot_row[i];
            end
            held--;
            ncopy = hl;
            if (ncopy > mc) ncopy = mc;
            if (ncopy > PayMax) ncopy = PayMax;
            push(ST_OK, hp, hh, hl, 0, ncopy == 0);
            for (int i = 0; i < ncopy; i++) push(ST_BYTE, 0, 0, 0, row[i], i + 1 == ncopy);
          end
        end
        default: begin
          held = 0;
          pend_v = 0;
          seen = 0;
          push(ST_OK, 0, 0, 0, 0, 1);
        end
      endcase
    endfunction

    function void check_result(qresult_t got);
      qresult_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result st=%0d cnt=%0d", $realtime, got.status, got.count);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        $display("%0t: exp st=%0d pri=%h hdr=%h len=%0d byte=%h last=%b cnt=%0d emp=%b",
                 $realtime, want.status, want.pri, want.hdr, want.flen, want.byte_v,
                 want.last, want.count, want.empty);
        $display("%0t: act st=%0d pri=%h hdr=%h len=%0d byte=%h last=%b cnt=%0d emp=%b",
                 $realtime, got.status, got.pri, got.hdr, got.flen, got.byte_v,
                 got.last, got.count, got.empty);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  mode_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [31:0] header_word_i = '0;
  logic [7:0]  message_length_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [7:0]  max_copy_i = '0;
  wire         busy, done_o, last_o, is_empty_o;
  wire [2:0]   status_o;
  wire [7:0]   out_priority_o, out_byte_o;
  wire [31:0]  out_header_o;
  wire [5:0]   full_length_o;
  wire [4:0]   count_o;

  sorted_priority_message_queue_top u_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .priority_req_i, .header_word_i,
    .message_length_i, .data_byte_i, .max_copy_i, .done_o, .status_o, .out_priority_o,
    .out_header_o, .full_length_o, .out_byte_o, .last_o, .count_o, .is_empty_o
  );

  queue_scoreboard sb = new();
  int idle_pct = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Results are single-cycle strobes; no back-pressure to apply.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({status_o, out_priority_o, out_header_o, full_length_o, out_byte_o,
                       last_o, count_o, is_empty_o});
  end

  // Drive one word until it is taken; idle cycles put random values on mode and data byte.
  task automatic send_word(mode_e m, logic [7:0] p, logic [31:0] h, logic [7:0] len,
                           logic [7:0] db, logic [7:0] mc);
    bit taken;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        mode_i <= 2'($urandom);
        data_byte_i <= 8'($urandom);
      end else begin
        start <= 1'b1;
        mode_i <= m; priority_req_i <= p; header_word_i <= h;
        message_length_i <= len; data_byte_i <= db; max_copy_i <= mc;
        // hold the word until the block takes it
        forever begin
          @(posedge clk_i);
          if (!busy) break;
        end
        sb.note_word(m, p, h, len, db, mc);
        taken = 1;
      end
    end
  endtask

  task automatic enq_msg(logic [7:0] p, logic [31:0] h, int len);
    send_word(MODE_ENQ_HDR, p, h, len[7:0], 8'($urandom), 8'($urandom));
    for (int i = 0; i < len; i++) send_word(MODE_BYTE, 8'($urandom), $urandom, 8'($urandom),
                                            8'($urandom), 8'($urandom));
  endtask

  task automatic random_traffic(int n);
    int pick;
    int len;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      // mostly short payloads; up to full size now and then
      len = ($urandom_range(9) == 0) ? $urandom_range(PayMax) : $urandom_range(6);
      if (pick < 45) enq_msg(8'($urandom_range(7) * 36), $urandom, len);
      else if (pick < 80)
        send_word(MODE_DEQ, 8'($urandom), $urandom, 8'($urandom), 8'($urandom),
                  8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(8)));
      else if (pick < 83) send_word(MODE_CLEAR, 8'($urandom), $urandom, 8'($urandom),
                                    8'($urandom), 8'($urandom));
      else if (pick < 88) send_word(MODE_ENQ_HDR, 8'($urandom), $urandom,
                                    8'($urandom_range(255, PayMax + 1)), 8'($urandom),
                                    8'($urandom));
      else if (pick < 93) send_word(MODE_BYTE, 8'($urandom), $urandom, 8'($urandom),
                                    8'($urandom), 8'($urandom));
      else begin
        // broken message: header then fewer bytes than announced
        send_word(MODE_ENQ_HDR, 8'($urandom), $urandom, len[7:0] + 8'd2, 8'($urandom),
                  8'($urandom));
        for (int i = 0; i < len; i++) send_word(MODE_BYTE, 8'($urandom), $urandom,
                                                8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int waited;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send_word(MODE_DEQ, 8'h00, '0, '0, '0, 8'hFF);          // empty queue
    send_word(MODE_BYTE, '0, '0, '0, 8'hA5, '0);             // stray byte
    send_word(MODE_ENQ_HDR, 8'hFF, '1, 8'd33, '0, '0);       // too long
    send_word(MODE_ENQ_HDR, 8'h00, '1, 8'hFF, '0, '0);       // too long, max length
    enq_msg(8'hFF, 32'hFFFF_FFFF, PayMax);
    enq_msg(8'h00, 32'h0000_0000, 0);                         // empty payload
    enq_msg(8'h00, 32'h1234_5678, 1);                         // same priority, goes after
    send_word(MODE_ENQ_HDR, 8'h10, 32'hDEAD_BEEF, 8'd3, '0, '0);
    send_word(MODE_BYTE, '0, '0, '0, 8'hFF, '0);
    send_word(MODE_DEQ, '0, '0, '0, '0, 8'h00);               // dequeue while pending
    send_word(MODE_BYTE, '0, '0, '0, 8'h00, '0);
    send_word(MODE_BYTE, '0, '0, '0, 8'h5A, '0);
    send_word(MODE_ENQ_HDR, 8'h20, '0, 8'd4, '0, '0);
    send_word(MODE_ENQ_HDR, 8'h30, '1, 8'd0, '0, '0);        // abandons the one above
    send_word(MODE_DEQ, '0, '0, '0, '0, 8'hFF);
    send_word(MODE_DEQ, '0, '0, '0, '0, 8'hFF);
    send_word(MODE_DEQ, '0, '0, '0, '0, 8'h01);
    for (int i = 0; i < Depth; i++) enq_msg(i[7:0] ^ 8'h0F, $urandom, 0);
    send_word(MODE_ENQ_HDR, 8'h00, '1, 8'd2, '0, '0);        // full
    send_word(MODE_BYTE, '0, '0, '0, 8'h77, '0);
    send_word(MODE_DEQ, '0, '0, '0, '0, 8'hFF);
    send_word(MODE_ENQ_HDR, 8'h40, '0, 8'd2, '0, '0);
    send_word(MODE_CLEAR, '0, '0, '0, '0, '0);                // clear while pending
    send_word(MODE_BYTE, '0, '0, '0, 8'h11, '0);
    enq_msg(8'hFF, 32'hFFFF_FFFF, PayMax);
    send_word(MODE_DEQ, '0, '0, '0, '0, 8'hFF);               // longest dequeue

    idle_pct = 20;
    random_traffic(20);
    idle_pct = 80;
    random_traffic(20);
    idle_pct = 0;
    random_traffic(20);
    @(negedge clk_i);
    start <= 1'b0;

    waited = 0;
    while (sb.due_q.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/spmq_pkg.sv
hw/rtl/spmq_payload_ram.sv
hw/rtl/spmq_cell.sv
hw/rtl/sorted_priority_message_queue_top.sv
bench/tb_top.sv
